// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the flat region detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FRD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define FRD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define FRD_ASSERT(label, prop)
`define FRD_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ----- rtl/frd_pkg.sv -----
// ----------------------------------------------------------------------------
// Flat region detector package
// Shared widths, register indexes and the word passed from front to back.
// ----------------------------------------------------------------------------
package frd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int INDEX_W = 24;
   localparam int SUM_W = 22;
   localparam int SQ_W = 37;
   localparam int CNT_W = 11;
   localparam int LIMIT_W = 44;
   localparam int HW_W = 6;
   localparam int WL_W = 11;
   localparam int PROD_W = 48;
   localparam int QUEUE_DEPTH = 8;
   localparam int QA_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 44;
   localparam int MAX_HALF_WIN_DEF = 32;
   localparam int MAX_SUBSEQ_LEN_DEF = 1024;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_WINDOW = 4'd0,
      CSR_WINDOW_LENGTH = 4'd1,
      CSR_VARIANCE_LIMIT = 4'd2,
      CSR_MIN_NONFLAT = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic [INDEX_W-1:0] centre;
      logic [INDEX_W-1:0] sample_index;
      logic               retire;
      logic               flag;
      logic               last;
   } cmd_type;

endpackage

// ----- rtl/frd_front.sv -----
// ----------------------------------------------------------------------------
// Front end
// Accepts samples, keeps the running sums and flags centres whose variance exceeds the limit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frd_front #(
   parameter int MAX_HALF_WIN = frd_pkg::MAX_HALF_WIN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [frd_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                                req_last_sample,
   input  logic [$clog2(MAX_HALF_WIN+1)-1:0]   half_win,
   input  logic [frd_pkg::LIMIT_W-1:0]         variance_limit,
   input  logic [frd_pkg::QCNT_W-1:0]          queue_count,
   output logic                                cmd_valid,
   output frd_pkg::cmd_type                    cmd
);

   localparam int SDEPTH = 2 * MAX_HALF_WIN + 1;
   localparam int PW = $clog2(SDEPTH);
   localparam int NW = $clog2(SDEPTH + 1);
   localparam int IW = frd_pkg::INDEX_W;
   localparam int SW = frd_pkg::SAMPLE_W;
   localparam int QW = frd_pkg::QCNT_W + 1;

   logic signed [SW-1:0] sample_mem [SDEPTH];

   logic [IW-1:0] count_ff, count_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [PW-1:0] rd_addr;
   logic [PW:0]   rd_tmp;
   logic [NW-1:0] nwin;
   logic [IW-1:0] idx_next;
   logic          acc;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [SW-1:0] x1_ff, old1_ff;
   logic                 use_old1_ff, full1_ff, retire1_ff, last1_ff;
   logic [IW-1:0]        centre1_ff, idx1_ff;

   logic [2*SW-1:0] xsq2_ff, oldsq2_ff;
   logic signed [SW-1:0] x2_ff, old2_ff;
   logic            full2_ff, retire2_ff, last2_ff;
   logic [IW-1:0]   centre2_ff, idx2_ff;

   logic [frd_pkg::SUM_W-1:0] sum_ff, sum_in, new_sum, sum3_ff;
   logic [frd_pkg::SQ_W-1:0]  sq_ff, sq_in, new_sq, sq3_ff;
   logic                      full3_ff, retire3_ff, last3_ff;
   logic [IW-1:0]             centre3_ff, idx3_ff;

   logic [frd_pkg::PROD_W-1:0]         p1_4_ff;
   logic signed [frd_pkg::PROD_W-1:0]  ss4_ff, diff;
   logic signed [2*frd_pkg::SUM_W-1:0] ssq;
   logic                               full4_ff, retire4_ff, last4_ff;
   logic [IW-1:0]                      centre4_ff, idx4_ff;
   logic [QW-1:0]                      credit;

   assign nwin = NW'({half_win, 1'b1});
   assign acc = req_valid && req_ready;
   assign credit = QW'(queue_count) + QW'(v1_ff) + QW'(v2_ff) + QW'(v3_ff) + QW'(v4_ff);
   assign req_ready = credit < QW'(frd_pkg::QUEUE_DEPTH);

   always_comb begin
      rd_tmp = (PW+1)'(ptr_ff) + (PW+1)'(SDEPTH) - (PW+1)'(nwin);
      if (rd_tmp >= (PW+1)'(SDEPTH)) begin
         rd_tmp = rd_tmp - (PW+1)'(SDEPTH);
      end
      rd_addr = PW'(rd_tmp);
      idx_next = count_ff + IW'(1);
      count_in = count_ff;
      ptr_in = ptr_ff;
      if (acc) begin
         if (req_last_sample) begin
            count_in = '0;
         end else begin
            count_in = idx_next;
         end
         if (req_last_sample || idx_next == '0 || ptr_ff == PW'(SDEPTH - 1)) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         sample_mem[ptr_ff] <= req_sample_value;
         old1_ff <= sample_mem[rd_addr];
      end
   end

   always_comb begin
      new_sum = sum_ff - frd_pkg::SUM_W'(old2_ff) + frd_pkg::SUM_W'(x2_ff);
      new_sq = sq_ff - frd_pkg::SQ_W'(oldsq2_ff) + frd_pkg::SQ_W'(xsq2_ff);
      sum_in = sum_ff;
      sq_in = sq_ff;
      if (v2_ff) begin
         sum_in = last2_ff ? '0 : new_sum;
         sq_in = last2_ff ? '0 : new_sq;
      end
      ssq = $signed(sum3_ff) * $signed(sum3_ff);
      diff = $signed(p1_4_ff) - ss4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff <= '0;
         sum_ff <= '0;
         sq_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ptr_ff <= ptr_in;
         sum_ff <= sum_in;
         sq_ff <= sq_in;
         v1_ff <= acc;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= req_sample_value;
      use_old1_ff <= count_ff >= IW'(nwin);
      full1_ff <= count_ff >= IW'({half_win, 1'b0});
      retire1_ff <= count_ff >= IW'(half_win);
      centre1_ff <= count_ff - IW'(half_win);
      idx1_ff <= count_ff;
      last1_ff <= req_last_sample;

      x2_ff <= x1_ff;
      old2_ff <= use_old1_ff ? old1_ff : '0;
      xsq2_ff <= (2*SW)'(x1_ff * x1_ff);
      oldsq2_ff <= use_old1_ff ? (2*SW)'(old1_ff * old1_ff) : '0;
      full2_ff <= full1_ff;
      retire2_ff <= retire1_ff;
      centre2_ff <= centre1_ff;
      idx2_ff <= idx1_ff;
      last2_ff <= last1_ff;

      sum3_ff <= new_sum;
      sq3_ff <= new_sq;
      full3_ff <= full2_ff;
      retire3_ff <= retire2_ff;
      centre3_ff <= centre2_ff;
      idx3_ff <= idx2_ff;
      last3_ff <= last2_ff;

      p1_4_ff <= frd_pkg::PROD_W'(nwin) * frd_pkg::PROD_W'(sq3_ff);
      ss4_ff <= frd_pkg::PROD_W'(ssq);
      full4_ff <= full3_ff;
      retire4_ff <= retire3_ff;
      centre4_ff <= centre3_ff;
      idx4_ff <= idx3_ff;
      last4_ff <= last3_ff;
   end

   assign cmd_valid = v4_ff && (retire4_ff || last4_ff);
   assign cmd.centre = centre4_ff;
   assign cmd.sample_index = idx4_ff;
   assign cmd.retire = retire4_ff;
   assign cmd.flag = full4_ff && (diff > $signed(frd_pkg::PROD_W'(variance_limit)));
   assign cmd.last = last4_ff;

   `FRD_ASSERT_NEXT(a_series_clear, acc && req_last_sample, count_ff == '0)

endmodule

// ----- rtl/frd_queue.sv -----
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frd_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  frd_pkg::cmd_type             push_data,
   input  logic                         pop,
   output logic                         out_valid,
   output frd_pkg::cmd_type             out_data,
   output logic [frd_pkg::QCNT_W-1:0]   count
);

   frd_pkg::cmd_type entries [frd_pkg::QUEUE_DEPTH];

   logic [frd_pkg::QA_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [frd_pkg::QCNT_W-1:0] count_ff, count_in;

   assign out_valid = count_ff != '0;
   assign out_data = entries[rd_ptr_ff];
   assign count = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + frd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - frd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + frd_pkg::QA_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + frd_pkg::QA_W'(1);
         end
      end
   end

   `FRD_ASSERT(a_no_overflow, !push || pop || count_ff < frd_pkg::QCNT_W'(frd_pkg::QUEUE_DEPTH))
   `FRD_ASSERT(a_no_underflow, !pop || count_ff != '0)

endmodule

// ----- rtl/frd_back.sv -----
// ----------------------------------------------------------------------------
// Back end
// Retires centres one per cycle unless stalled; keeps non-flat count, emits decisions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frd_back #(
   parameter int MAX_SUBSEQ_LEN = frd_pkg::MAX_SUBSEQ_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  frd_pkg::cmd_type                  q_data,
   output logic                              q_pop,
   input  logic [$clog2(MAX_SUBSEQ_LEN+1)-1:0] sub_len,
   input  logic [frd_pkg::CNT_W-1:0]         min_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [frd_pkg::INDEX_W-1:0]       rsp_start_index,
   output logic                              rsp_is_flat,
   output logic                              rsp_last_result
);

   localparam int FAW = $clog2(MAX_SUBSEQ_LEN);
   localparam int IW = frd_pkg::INDEX_W;
   localparam int CW = frd_pkg::CNT_W;

   logic flag_mem [2**FAW];

   logic          norm_ff, flush_ff, flag_ff;
   logic [IW-1:0] c_ff, end_ff;
   logic          busy, op_flag, op_final, finishing, en, a_fire;
   logic [IW-1:0] rd_full;

   logic          b_valid_ff, b_flag_ff, b_has_old_ff, b_emit_ff, b_final_ff, b_old_ff;
   logic [IW-1:0] b_c_ff;
   logic [CW:0]   cnt;
   logic [CW-1:0] cnt_sat;
   logic [CW-1:0] count_ff;

   logic          rsp_valid_ff;
   logic [IW-1:0] rsp_index_ff;
   logic          rsp_flat_ff, rsp_last_ff;

   assign en = !rsp_valid_ff || rsp_ready;
   assign busy = norm_ff || flush_ff;
   assign op_flag = norm_ff ? flag_ff : 1'b0;
   assign op_final = !norm_ff && flush_ff && c_ff == end_ff;
   assign finishing = (norm_ff && !flush_ff) || op_final;
   assign q_pop = en && q_valid && (!busy || finishing);
   assign a_fire = en && busy;
   assign rd_full = c_ff - IW'(sub_len);

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff <= 1'b0;
         flush_ff <= 1'b0;
      end else if (q_pop) begin
         norm_ff <= q_data.retire;
         flush_ff <= q_data.last;
      end else if (a_fire) begin
         norm_ff <= 1'b0;
         if (op_final) begin
            flush_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         c_ff <= q_data.retire ? q_data.centre : '0;
         end_ff <= q_data.sample_index;
         flag_ff <= q_data.flag;
      end else if (a_fire) begin
         c_ff <= c_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         flag_mem[c_ff[FAW-1:0]] <= op_flag;
         b_old_ff <= flag_mem[rd_full[FAW-1:0]];
         b_c_ff <= c_ff;
         b_flag_ff <= op_flag;
         b_has_old_ff <= c_ff >= IW'(sub_len);
         b_emit_ff <= (IW+1)'(c_ff) + (IW+1)'(1) >= (IW+1)'(sub_len);
         b_final_ff <= op_final;
      end
   end

   always_comb begin
      cnt = (CW+1)'(count_ff) + (CW+1)'(b_flag_ff);
      if (b_has_old_ff) begin
         if (cnt >= (CW+1)'(b_old_ff)) begin
            cnt = cnt - (CW+1)'(b_old_ff);
         end else begin
            cnt = '0;
         end
      end
      if (cnt > (CW+1)'(frd_pkg::COUNT_MAX)) begin
         cnt_sat = frd_pkg::COUNT_MAX;
      end else begin
         cnt_sat = CW'(cnt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_fire;
         rsp_valid_ff <= b_valid_ff && b_emit_ff;
         if (b_valid_ff) begin
            count_ff <= b_final_ff ? '0 : cnt_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_index_ff <= b_c_ff + IW'(1) - IW'(sub_len);
         rsp_flat_ff <= cnt_sat < min_count;
         rsp_last_ff <= b_final_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_start_index = rsp_index_ff;
   assign rsp_is_flat = rsp_flat_ff;
   assign rsp_last_result = rsp_last_ff;

   `FRD_ASSERT(a_flush_range, !flush_ff || c_ff <= end_ff)
   `FRD_ASSERT_NEXT(a_hold_on_stall, rsp_valid_ff && !rsp_ready, rsp_valid_ff)

endmodule

// ----- rtl/flat_region_detector.sv -----
// An accepted word passes the front end's pipeline into the retire queue, then
// the back end's sequencer, stage B and response register. Throughput: one
// sample per cycle while the queue has room; a word with the end-of-series mark
// also retires up to R further centres, one per cycle while the receiver is
// ready, in the back end's sequencer. Reset is synchronous, restores register
// defaults, zeroes sums, counts and pointers; delay memories are not cleared.
// ----------------------------------------------------------------------------
// Flat region detector
// Moving-window variance test on pitch samples with flat subsequence flags.
// ----------------------------------------------------------------------------

module flat_region_detector #(
   parameter int MAX_HALF_WIN = frd_pkg::MAX_HALF_WIN_DEF,
   parameter int MAX_SUBSEQ_LEN = frd_pkg::MAX_SUBSEQ_LEN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [frd_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                                req_last_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [frd_pkg::INDEX_W-1:0]         rsp_start_index,
   output logic                                rsp_is_flat,
   output logic                                rsp_last_result,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [frd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [frd_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int RW = $clog2(MAX_HALF_WIN + 1);
   localparam int LW = $clog2(MAX_SUBSEQ_LEN + 1);

   logic [frd_pkg::HW_W-1:0]    half_window_ff;
   logic [frd_pkg::WL_W-1:0]    window_length_ff;
   logic [frd_pkg::LIMIT_W-1:0] variance_limit_ff;
   logic [frd_pkg::CNT_W-1:0]   min_nonflat_ff;
   logic [RW-1:0]               half_eff;
   logic [LW-1:0]               len_eff;

   logic                       cmd_valid, q_valid, q_pop;
   frd_pkg::cmd_type           cmd, q_data;
   logic [frd_pkg::QCNT_W-1:0] q_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_window_ff <= frd_pkg::HW_W'(4);
         window_length_ff <= frd_pkg::WL_W'(100);
         variance_limit_ff <= '0;
         min_nonflat_ff <= '0;
      end else if (csr_valid) begin
         unique case (frd_pkg::csr_index_type'(csr_index))
            frd_pkg::CSR_HALF_WINDOW: begin
               half_window_ff <= csr_data[frd_pkg::HW_W-1:0];
            end
            frd_pkg::CSR_WINDOW_LENGTH: begin
               window_length_ff <= csr_data[frd_pkg::WL_W-1:0];
            end
            frd_pkg::CSR_VARIANCE_LIMIT: begin
               variance_limit_ff <= csr_data[frd_pkg::LIMIT_W-1:0];
            end
            frd_pkg::CSR_MIN_NONFLAT: begin
               min_nonflat_ff <= csr_data[frd_pkg::CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (half_window_ff == '0) begin
         half_eff = RW'(1);
      end else if (32'(half_window_ff) > 32'(MAX_HALF_WIN)) begin
         half_eff = RW'(MAX_HALF_WIN);
      end else begin
         half_eff = RW'(half_window_ff);
      end
      if (window_length_ff == '0) begin
         len_eff = LW'(1);
      end else if (32'(window_length_ff) > 32'(MAX_SUBSEQ_LEN)) begin
         len_eff = LW'(MAX_SUBSEQ_LEN);
      end else begin
         len_eff = LW'(window_length_ff);
      end
   end

   frd_front #(
      .MAX_HALF_WIN(MAX_HALF_WIN)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_value(req_sample_value),
      .req_last_sample(req_last_sample),
      .half_win(half_eff),
      .variance_limit(variance_limit_ff),
      .queue_count(q_count),
      .cmd_valid(cmd_valid),
      .cmd(cmd)
   );

   frd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(cmd_valid),
      .push_data(cmd),
      .pop(q_pop),
      .out_valid(q_valid),
      .out_data(q_data),
      .count(q_count)
   );

   frd_back #(
      .MAX_SUBSEQ_LEN(MAX_SUBSEQ_LEN)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_data(q_data),
      .q_pop(q_pop),
      .sub_len(len_eff),
      .min_count(min_nonflat_ff),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_start_index(rsp_start_index),
      .rsp_is_flat(rsp_is_flat),
      .rsp_last_result(rsp_last_result)
   );

endmodule

// ----- sim/flat_region_detector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flat region detector testbench
// Streams pitch series through the detector under random sender gaps and
// receiver stalls, predicts every flat decision in the bench itself and
// compares each decision word field by field.
// ----------------------------------------------------------------------------

module flat_region_detector_tb;

   typedef struct {
      logic signed [frd_pkg::SAMPLE_W-1:0] value;
      logic                                last;
   } sample_word_type;

   typedef struct {
      logic [frd_pkg::INDEX_W-1:0] start_index;
      logic                        is_flat;
      logic                        last_result;
   } decision_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [frd_pkg::SAMPLE_W-1:0] req_sample_value = '0;
   logic req_last_sample = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [frd_pkg::INDEX_W-1:0] rsp_start_index;
   logic rsp_is_flat;
   logic rsp_last_result;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [frd_pkg::CSR_IDX_W-1:0] csr_index = frd_pkg::CSR_HALF_WINDOW;
   logic [frd_pkg::CSR_DATA_W-1:0] csr_data = '0;

   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   int errors = 0;

   sample_word_type pending_samples[$];
   decision_type expected_decisions[$];

   // Predictor state and register copies.
   logic [frd_pkg::HW_W-1:0] cfg_half_window = 6'd4;
   logic [frd_pkg::WL_W-1:0] cfg_window_length = 11'd100;
   logic [frd_pkg::LIMIT_W-1:0] cfg_variance_limit = '0;
   logic [frd_pkg::CNT_W-1:0] cfg_min_nonflat = '0;
   logic signed [frd_pkg::SAMPLE_W-1:0] pitch_history[65];
   bit flag_history[1024];
   logic [frd_pkg::SUM_W-1:0] run_sum = '0;
   logic [frd_pkg::SQ_W-1:0] run_sum_sq = '0;
   int unsigned nonflat_total = 0;
   logic [frd_pkg::INDEX_W-1:0] series_pos = '0;

   flat_region_detector dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic void retire_centre(input longint c, input bit flag, input longint len);
      int unsigned cnt;
      int unsigned old;
      decision_type d;
      cnt = nonflat_total + flag;
      if (c >= len) begin
         old = flag_history[(c - len) % 1024];
         cnt = (cnt >= old) ? cnt - old : 0;
      end
      if (cnt > 2047) cnt = 2047;
      flag_history[c % 1024] = flag;
      nonflat_total = cnt;
      if (c + 1 >= len) begin
         d.start_index = frd_pkg::INDEX_W'(c + 1 - len);
         d.is_flat = (cnt < cfg_min_nonflat);
         d.last_result = 1'b0;
         expected_decisions.push_back(d);
      end
   endfunction

   function automatic void predict_sample(input logic signed [frd_pkg::SAMPLE_W-1:0] x,
                                          input bit last);
      longint r;
      longint len;
      longint i;
      longint nwin;
      longint s;
      longint diff;
      longint c;
      longint oldv;
      int before_n;
      bit flag;
      r = cfg_half_window;
      len = cfg_window_length;
      i = series_pos;
      before_n = expected_decisions.size();
      if (r < 1) r = 1;
      if (r > 32) r = 32;
      if (len < 1) len = 1;
      if (len > 1024) len = 1024;
      nwin = 2 * r + 1;
      if (i >= nwin) begin
         oldv = pitch_history[(i - nwin) % 65];
         run_sum = run_sum - frd_pkg::SUM_W'(oldv);
         run_sum_sq = run_sum_sq - frd_pkg::SQ_W'(oldv * oldv);
      end
      pitch_history[i % 65] = x;
      run_sum = run_sum + frd_pkg::SUM_W'(longint'(x));
      run_sum_sq = run_sum_sq + frd_pkg::SQ_W'(longint'(x) * longint'(x));
      if (i >= r) begin
         flag = 1'b0;
         if (i >= 2 * r) begin
            s = longint'($signed(run_sum));
            diff = nwin * longint'(run_sum_sq) - s * s;
            flag = (diff > longint'(cfg_variance_limit));
         end
         retire_centre(i - r, flag, len);
      end
      if (last) begin
         c = (i >= r) ? i - r + 1 : 0;
         for (; c <= i; c++) retire_centre(c, 1'b0, len);
         if (expected_decisions.size() > before_n)
            expected_decisions[$].last_result = 1'b1;
         run_sum = '0;
         run_sum_sq = '0;
         nonflat_total = 0;
         series_pos = '0;
      end else begin
         series_pos = series_pos + 1'b1;
      end
   endfunction

   // Acceptance tracking, prediction and decision checking.
   always @(posedge clock) begin
      decision_type d;
      req_taken <= req_valid && req_ready;
      csr_taken <= csr_valid && csr_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (frd_pkg::csr_index_type'(csr_index))
               frd_pkg::CSR_HALF_WINDOW:
                  cfg_half_window = csr_data[frd_pkg::HW_W-1:0];
               frd_pkg::CSR_WINDOW_LENGTH:
                  cfg_window_length = csr_data[frd_pkg::WL_W-1:0];
               frd_pkg::CSR_VARIANCE_LIMIT:
                  cfg_variance_limit = csr_data[frd_pkg::LIMIT_W-1:0];
               frd_pkg::CSR_MIN_NONFLAT:
                  cfg_min_nonflat = csr_data[frd_pkg::CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_sample(req_sample_value, req_last_sample);
         if (rsp_valid && rsp_ready) begin
            if (expected_decisions.size() == 0) begin
               $display("%0t: unexpected word: index %0d flat %0b last %0b", $time,
                  rsp_start_index, rsp_is_flat, rsp_last_result);
               errors++;
            end else begin
               d = expected_decisions.pop_front();
               if (rsp_start_index !== d.start_index) begin
                  $display("%0t: start_index expected %0d actual %0d", $time,
                     d.start_index, rsp_start_index);
                  errors++;
               end
               if (rsp_is_flat !== d.is_flat) begin
                  $display("%0t: is_flat expected %0b actual %0b (index %0d)", $time,
                     d.is_flat, rsp_is_flat, d.start_index);
                  errors++;
               end
               if (rsp_last_result !== d.last_result) begin
                  $display("%0t: last_result expected %0b actual %0b (index %0d)", $time,
                     d.last_result, rsp_last_result, d.start_index);
                  errors++;
               end
            end
         end
      end
   end

   // Sample driver with bursts and gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      sample_word_type w;
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            w = pending_samples.pop_front();
            req_sample_value <= w.value;
            req_last_sample <= w.last;
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(0, 20);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver stalls on a rotating pattern.
   int stall_tick = 0;
   always @(negedge clock) begin
      stall_tick++;
      case ((stall_tick / 97) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= (stall_tick % 3) != 0;
         2: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   task automatic write_reg(input frd_pkg::csr_index_type idx,
                            input logic [frd_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [frd_pkg::CSR_DATA_W-1:0] hw,
                            input logic [frd_pkg::CSR_DATA_W-1:0] wl,
                            input logic [frd_pkg::CSR_DATA_W-1:0] vl,
                            input logic [frd_pkg::CSR_DATA_W-1:0] mn);
      write_reg(frd_pkg::CSR_HALF_WINDOW, hw);
      write_reg(frd_pkg::CSR_WINDOW_LENGTH, wl);
      write_reg(frd_pkg::CSR_VARIANCE_LIMIT, vl);
      write_reg(frd_pkg::CSR_MIN_NONFLAT, mn);
   endtask

   task automatic drain;
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_decisions.size() != 0);
      repeat (60) @(negedge clock);
   endtask

   function automatic void push_sample(input logic signed [frd_pkg::SAMPLE_W-1:0] v,
                                       input bit last);
      sample_word_type w;
      w.value = v;
      w.last = last;
      pending_samples.push_back(w);
   endfunction

   // A series of flat and rough stretches around a random base pitch.
   function automatic void push_series(input int count, input bit close);
      int base;
      int spread;
      int v;
      base = $urandom_range(0, 8000) - 4000;
      spread = 2;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 7) == 0)
            spread = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(50, 1500);
         v = base + $urandom_range(0, 2 * spread) - spread;
         if ($urandom_range(0, 19) == 0) v = $signed(16'($urandom()));
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         push_sample(frd_pkg::SAMPLE_W'(v), close && (k == count - 1));
      end
   endfunction

   initial begin
      int hw;
      int wl;
      int thr;
      longint unsigned nw;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Defaults: a series shorter than the subsequence length gives nothing.
      push_sample(16'sh7fff, 0);
      push_sample(-16'sh8000, 0);
      push_sample(16'sh0000, 0);
      push_sample(-16'sh0001, 1);
      drain();

      // Zero half window and length clamp to one.
      configure(0, 0, 0, 1);
      push_sample(16'sh7fff, 0);
      push_sample(-16'sh8000, 0);
      push_sample(16'sh7fff, 0);
      push_sample(-16'sh8000, 0);
      push_sample(16'sh0000, 0);
      push_sample(16'sh0000, 1);
      push_sample(16'sh1234, 1);
      push_sample(16'sh5555, 0);
      push_sample(-16'sh5556, 1);
      drain();

      // Oversized half window clamps; end of series flushes the most centres.
      configure(63, 3, 44'hfff_ffff_ffff, 2047);
      push_series(70, 1);
      drain();

      // Oversized length clamps; a short series emits nothing.
      configure(32, 2047, 44'h0, 5);
      push_series(6, 1);
      drain();

      for (int p = 0; p < 3; p++) begin
         hw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6);
         wl = $urandom_range(1, 30);
         thr = $urandom_range(0, 300);
         nw = (hw < 1) ? 3 : ((hw > 32) ? 65 : 2 * hw + 1);
         configure(frd_pkg::CSR_DATA_W'(hw), frd_pkg::CSR_DATA_W'(wl),
                   frd_pkg::CSR_DATA_W'(nw * nw * thr * thr),
                   frd_pkg::CSR_DATA_W'($urandom_range(0, wl + 1)));
         push_series($urandom_range(10, 60), 1);
         // Sometimes the series stays open across the next register change.
         push_series($urandom_range(5, 30), $urandom_range(0, 2) != 0);
         drain();
      end
      push_series(20, 1);
      drain();

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
